[hdl/mbps_pkg.sv]
// mbps_pkg: shared types and constants of the masked byte pattern scanner
// no dependencies

package mbps_pkg;

    localparam int PAT_BYTES = 16;
    localparam int PAT_IDX_W = 4;
    localparam int LEN_W     = 5;
    localparam int OFFSET_W  = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CARE_BITS    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN  = 2'd3;

    typedef logic [PAT_BYTES-1:0][7:0] pattern_t;

    typedef struct packed {
        logic                found;
        logic [OFFSET_W-1:0] match_offset;
    } result_t;

endpackage

[hdl/mbps_cell.sv]
// mbps_cell: one window byte of the scanner and its aligned pattern compare
// depends on mbps_pkg

module mbps_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                          clk,
    input  logic                          shift_en,
    input  logic [7:0]                    byte_in,
    output logic [7:0]                    byte_out,
    input  mbps_pkg::pattern_t            pattern,
    input  logic [mbps_pkg::PAT_BYTES-1:0] care,
    input  logic [mbps_pkg::LEN_W-1:0]    len,
    output logic                          ok
);

    logic [7:0]                    byte_reg;
    logic [7:0]                    byte_next;
    logic [mbps_pkg::LEN_W-1:0]    pat_pos;
    logic [mbps_pkg::PAT_IDX_W-1:0] pat_idx;
    logic                          in_use;

    assign byte_next = shift_en ? byte_in : byte_reg;
    assign byte_out  = byte_reg;

    // window position k lines up with pattern byte len-1-k
    assign in_use  = mbps_pkg::LEN_W'(CELL_IDX) < len;
    assign pat_pos = len - mbps_pkg::LEN_W'(CELL_IDX) - mbps_pkg::LEN_W'(1);
    assign pat_idx = pat_pos[mbps_pkg::PAT_IDX_W-1:0];

    // compare the byte this cell holds after the shift
    assign ok = !in_use || !care[pat_idx] || (byte_in == pattern[pat_idx]);

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

endmodule

[hdl/mbps_out_buf.sv]
// mbps_out_buf: output register plus skid stage for scan results
// depends on mbps_pkg

module mbps_out_buf (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  mbps_pkg::result_t            push_data,
    output logic                         full,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [mbps_pkg::OFFSET_W-1:0] m_tdata,
    output logic                         m_tuser
);

    logic              main_valid_reg;
    logic              main_valid_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    mbps_pkg::result_t main_reg;
    mbps_pkg::result_t main_next;
    mbps_pkg::result_t skid_reg;
    mbps_pkg::result_t skid_next;
    logic              pop;

    assign pop = main_valid_reg && m_tready;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                skid_valid_next = push;
                skid_next       = push_data;
            end
            else
            begin
                main_valid_next = push;
                main_next       = push_data;
            end
        end
        else if (!main_valid_reg)
        begin
            main_valid_next = push;
            main_next       = push_data;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_next       = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign full     = skid_valid_reg;
    assign m_tvalid = main_valid_reg;
    assign m_tdata  = main_reg.match_offset;
    assign m_tuser  = main_reg.found;

endmodule

[hdl/masked_byte_pattern_scanner_core.sv]
// masked_byte_pattern_scanner_core: top level, wildcard byte signature scan
// depends on mbps_pkg, mbps_cell, mbps_out_buf
// each result is registered in mbps_out_buf and reaches m_tvalid behind any earlier results
// throughput: one byte per cycle; all pattern positions compare in parallel
// in the row of window cells; s_tready drops only while both output stages
// hold results. reset clears configuration, byte count, report flag and
// the output stages; window bytes are not cleared

module masked_byte_pattern_scanner_core #(
    parameter int MAX_PATTERN = 16,
    parameter int OFFSET_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] data_byte
    input  logic                          s_tlast,   // end_of_data
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mbps_pkg::OFFSET_W-1:0] m_tdata,   // [31:0] match_offset
    output logic                          m_tuser,   // [0] found
    input  logic                          cfg_we,
    input  logic [mbps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mbps_pkg::CFG_W-1:0]    cfg_wdata
);

    localparam int OFF_EFF = (OFFSET_BITS > 32) ? 32 : OFFSET_BITS;
    localparam int CW      = OFF_EFF + 1;
    localparam logic [CW-1:0] LIM = {1'b0, {OFF_EFF{1'b1}}};

    logic [63:0]                    pat_low_reg;
    logic [63:0]                    pat_high_reg;
    logic [mbps_pkg::PAT_BYTES-1:0] care_reg;
    logic [mbps_pkg::LEN_W-1:0]     len_reg;

    logic [CW-1:0] seen_reg;
    logic [CW-1:0] seen_next;
    logic          reported_reg;
    logic          reported_next;

    mbps_pkg::pattern_t         pattern;
    logic [mbps_pkg::LEN_W-1:0] len_eff;
    logic [7:0]                 chain [MAX_PATTERN+1];
    logic [MAX_PATTERN-1:0]     cell_ok;
    logic                       accept;
    logic                       full;
    logic                       hit;
    logic                       enough;
    logic [CW-1:0]              start;
    logic [CW-1:0]              start_sat;
    logic                       push;
    mbps_pkg::result_t          push_data;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            care_reg     <= '0;
            len_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mbps_pkg::CFG_PATTERN_LOW:  pat_low_reg  <= cfg_wdata;
                mbps_pkg::CFG_PATTERN_HIGH: pat_high_reg <= cfg_wdata;
                mbps_pkg::CFG_CARE_BITS:    care_reg     <= cfg_wdata[mbps_pkg::PAT_BYTES-1:0];
                mbps_pkg::CFG_PATTERN_LEN:  len_reg      <= cfg_wdata[mbps_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign pattern = {pat_high_reg, pat_low_reg};
    assign len_eff = (len_reg > mbps_pkg::LEN_W'(MAX_PATTERN))
                   ? mbps_pkg::LEN_W'(MAX_PATTERN) : len_reg;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    // window: cell k holds the k-th newest byte
    assign chain[0] = s_tdata;

    for (genvar k = 0; k < MAX_PATTERN; k++)
    begin : g_cell
        mbps_cell #(
            .CELL_IDX (k)
        ) u_cell (
            .clk      (clk),
            .shift_en (accept),
            .byte_in  (chain[k]),
            .byte_out (chain[k+1]),
            .pattern  (pattern),
            .care     (care_reg),
            .len      (len_eff),
            .ok       (cell_ok[k])
        );
    end

    // only windows wholly inside the stream count
    assign enough = (seen_reg + CW'(1)) >= CW'(len_eff);
    assign start  = seen_reg + CW'(1) - CW'(len_eff);

    always_comb
    begin
        if (len_eff == '0)
        begin
            hit       = !reported_reg;
            start_sat = '0;
        end
        else
        begin
            hit       = !reported_reg && (seen_reg == {CW{1'b1}} || enough) && (&cell_ok);
            start_sat = (seen_reg == {CW{1'b1}} || start > LIM) ? LIM : start;
        end
    end

    assign push                   = accept && (hit || (s_tlast && !reported_reg));
    assign push_data.found        = hit;
    assign push_data.match_offset = hit ? mbps_pkg::OFFSET_W'(start_sat) : '0;

    always_comb
    begin
        seen_next     = seen_reg;
        reported_next = reported_reg;
        if (accept)
        begin
            if (s_tlast)
            begin
                seen_next     = '0;
                reported_next = 1'b0;
            end
            else
            begin
                if (seen_reg != {CW{1'b1}})
                begin
                    seen_next = seen_reg + CW'(1);
                end
                reported_next = reported_reg || hit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg     <= '0;
            reported_reg <= 1'b0;
        end
        else
        begin
            seen_reg     <= seen_next;
            reported_reg <= reported_next;
        end
    end

    mbps_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

[verif/tb_top.sv]
// tb_top: self-checking bench for masked_byte_pattern_scanner_core
// depends on mbps_pkg and the scanner rtl; directed streams first, then random
// streams under changing patterns, with random stalls on both stream sides

module tb_top;

    // offset field saturates at 32 bits
    localparam logic [63:0] OFFSET_MAX = 64'hFFFF_FFFF;

    class match_tracker;
        logic [63:0]        pat_lo = '0;
        logic [63:0]        pat_hi = '0;
        logic [15:0]        care = '0;
        logic [4:0]         pat_len = '0;
        mbps_pkg::pattern_t window = '0;   // byte 0 is the newest
        logic [63:0]        seen = '0;
        bit                 reported = 1'b0;
        mbps_pkg::result_t  pending_reports[$];
        int                 errors = 0;

        function void set_reg(logic [mbps_pkg::CFG_IDX_W-1:0] idx,
                              logic [mbps_pkg::CFG_W-1:0] data);
            case (idx)
                mbps_pkg::CFG_PATTERN_LOW:  pat_lo = data;
                mbps_pkg::CFG_PATTERN_HIGH: pat_hi = data;
                mbps_pkg::CFG_CARE_BITS:    care = data[15:0];
                mbps_pkg::CFG_PATTERN_LEN:  pat_len = data[4:0];
                default: ;
            endcase
        endfunction

        function void take_byte(logic [7:0] b, logic last);
            int unsigned        len;
            int unsigned        j;
            bit                 hit;
            logic [63:0]        start;
            mbps_pkg::pattern_t pat;
            mbps_pkg::result_t  r;
            pat = {pat_hi, pat_lo};
            len = (pat_len > mbps_pkg::PAT_BYTES) ? mbps_pkg::PAT_BYTES : pat_len;
            window = {window[mbps_pkg::PAT_BYTES-2:0], b};
            hit = 1'b0;
            start = '0;
            if (!reported)
            begin
                if (len == 0)
                begin
                    hit = 1'b1;
                end
                else if (seen + 64'd1 >= 64'(len) || seen == '1)
                begin
                    // only windows wholly inside the stream count
                    hit = 1'b1;
                    for (j = 0; j < len; j++)
                        if (care[j] && window[len-1-j] != pat[j])
                            hit = 1'b0;
                    start = (seen == '1) ? '1 : seen + 64'd1 - 64'(len);
                end
            end
            if (seen != '1)
                seen++;
            if (hit)
            begin
                r.found = 1'b1;
                r.match_offset = (start > OFFSET_MAX) ? '1 : start[mbps_pkg::OFFSET_W-1:0];
                pending_reports = {pending_reports, r};
                reported = 1'b1;
            end
            else if (last && !reported)
            begin
                r.found = 1'b0;
                r.match_offset = '0;
                pending_reports = {pending_reports, r};
            end
            if (last)
            begin
                window = '0;
                seen = '0;
                reported = 1'b0;
            end
        endfunction

        function void note_fail(string msg);
            errors++;
            if (errors <= 10)
                $display("mismatch at %0t: %s", $time, msg);
        endfunction

        function void check_report(logic found, logic [mbps_pkg::OFFSET_W-1:0] offset);
            mbps_pkg::result_t want;
            if (pending_reports.size() == 0)
            begin
                note_fail($sformatf("unexpected word found=%0b offset=%0d", found, offset));
                return;
            end
            want = pending_reports.pop_front();
            if (want.found !== found || want.match_offset !== offset)
                note_fail($sformatf("found exp %0b got %0b, offset exp %0d got %0d",
                                    want.found, found, want.match_offset, offset));
        endfunction
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata = '0;
    logic                           s_tlast = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [mbps_pkg::OFFSET_W-1:0]  m_tdata;
    logic                           m_tuser;
    logic                           cfg_we = 1'b0;
    logic [mbps_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [mbps_pkg::CFG_W-1:0]     cfg_wdata = '0;

    match_tracker       tracker;
    logic [7:0]         stream_bytes[$];
    mbps_pkg::pattern_t cur_pat;
    logic [15:0]        cur_care;
    int unsigned        cur_len;
    bit                 calm = 1'b0;

    masked_byte_pattern_scanner_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                tracker.set_reg(cfg_index, cfg_wdata);
            if (s_tvalid && s_tready)
                tracker.take_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                tracker.check_report(m_tuser, m_tdata);
        end
    end

    always @(posedge clk)
    begin
        m_tready <= calm || ($urandom_range(0, 99) >= 13);
    end

    initial
    begin
        #2000000;
        $display("[masked_byte_pattern_scanner_core] ERROR");
        $finish;
    end

    task automatic write_reg(logic [mbps_pkg::CFG_IDX_W-1:0] idx,
                             logic [mbps_pkg::CFG_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic configure(logic [63:0] lo, logic [63:0] hi, logic [15:0] care_v,
                             logic [4:0] len_v);
        logic [63:0] junk;
        junk = {$urandom(), $urandom()};
        cur_pat  = {hi, lo};
        cur_care = care_v;
        cur_len  = (len_v > mbps_pkg::PAT_BYTES) ? mbps_pkg::PAT_BYTES : len_v;
        write_reg(mbps_pkg::CFG_PATTERN_LOW, lo);
        write_reg(mbps_pkg::CFG_PATTERN_HIGH, hi);
        // upper bits of the narrow registers carry junk
        write_reg(mbps_pkg::CFG_CARE_BITS, {junk[63:16], care_v});
        write_reg(mbps_pkg::CFG_PATTERN_LEN, {junk[63:5], len_v});
    endtask

    task automatic send_stream();
        int i;
        for (i = 0; i < stream_bytes.size(); i++)
        begin
            while (!calm && $urandom_range(0, 99) < 13)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= stream_bytes[i];
            s_tlast  <= (i == stream_bytes.size() - 1);
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
        end
    endtask

    // random bytes, usually with the pattern planted somewhere, sometimes spoiled
    task automatic build_stream(int n);
        int          i;
        int unsigned pos;
        int unsigned j;
        stream_bytes.delete();
        for (i = 0; i < n; i++)
            stream_bytes = {stream_bytes, 8'($urandom())};
        if (n >= cur_len && $urandom_range(0, 99) < 70)
        begin
            pos = $urandom_range(0, n - cur_len);
            for (j = 0; j < cur_len; j++)
                if (cur_care[j])
                    stream_bytes[pos + j] = cur_pat[j];
            if (cur_len != 0 && $urandom_range(0, 3) == 0)
            begin
                j = $urandom_range(0, cur_len - 1);
                if (cur_care[j])
                    stream_bytes[pos + j] = stream_bytes[pos + j] ^
                                            8'(1 << $urandom_range(0, 7));
            end
        end
    endtask

    // wait until every expected word is out, then for the output pipeline
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (tracker.pending_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int          phase;
        int          random_bytes;
        int          budget;
        int          n;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [15:0] care_v;
        logic [4:0]  len_v;

        tracker = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset config: empty pattern hits on the first byte, rest is silent
        stream_bytes = '{8'h00, 8'hFF};
        send_stream();
        settle();

        // unused pattern bytes and care bits above the length are junk
        configure(64'h0123_4567_EFBE_ADDE, 64'hA5A5_5A5A_FFFF_0000, 16'hFFFF, 5'd4);
        stream_bytes = '{8'hDE, 8'hAD, 8'hBE, 8'hEF, 8'h00};
        send_stream();
        stream_bytes = '{8'hDE, 8'hAD, 8'hBE};
        send_stream();
        stream_bytes = '{8'h11, 8'hDE, 8'hAD, 8'hBE, 8'hEF};
        send_stream();
        stream_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_stream();
        settle();

        // bytes 1 and 3 are wildcards
        configure(64'h0123_4567_EFBE_ADDE, 64'h0, 16'h0005, 5'd4);
        stream_bytes = '{8'hDE, 8'h00, 8'hBE, 8'hFF};
        send_stream();

        phase = 0;
        random_bytes = 0;
        while (random_bytes < 550)
        begin
            settle();
            lo     = {$urandom(), $urandom()};
            hi     = {$urandom(), $urandom()};
            care_v = 16'($urandom());
            len_v  = 5'($urandom_range(1, 16));
            case (phase % 6)
                0:
                begin
                    lo = '0;
                    hi = '1;
                    care_v = '1;
                    len_v = 5'd16;
                end
                1: len_v = 5'd31;
                2:
                begin
                    care_v = 16'h0001;
                    len_v = 5'd1;
                end
                3: len_v = 5'd0;
                4: care_v = '0;
                default: len_v = 5'($urandom_range(0, 31));
            endcase
            configure(lo, hi, care_v, len_v);
            calm = (phase == 2);
            budget = 0;
            while (budget < 90)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 60)
                                                : $urandom_range(1, 20);
                build_stream(n);
                send_stream();
                budget += n;
            end
            random_bytes += budget;
            calm = 1'b0;
            phase++;
        end

        settle();
        repeat (8) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending_reports.size() == 0)
            $display("[masked_byte_pattern_scanner_core] OK");
        else
            $display("[masked_byte_pattern_scanner_core] ERROR");
        $finish;
    end

endmodule
